### design/assert_macros.svh
// Assertion macros shared by the filter unit's controller and datapath.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

### design/mbq_pkg.sv
// Shared types and constants for the multichannel biquad filter unit.
// Used by the controller, the datapath, the register block and the top level.
package mbq_pkg;

    localparam int HIST_BITS     = 32;
    localparam int ACC_W         = 64;
    localparam int CFG_ADDR_BITS = 5;
    localparam int CHAN_BITS     = 3;
    localparam int ACTIVE_BITS   = 4;

    // Input command codes.
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_COEF_B0 = 3'd0;
    localparam logic [2:0] REG_COEF_B1 = 3'd1;
    localparam logic [2:0] REG_COEF_B2 = 3'd2;
    localparam logic [2:0] REG_COEF_A1 = 3'd3;
    localparam logic [2:0] REG_COEF_A2 = 3'd4;
    localparam logic [2:0] REG_ACTIVE  = 3'd5;

    typedef enum logic [2:0] {
        MUL_A1H1 = 3'd0,
        MUL_A2H2 = 3'd1,
        MUL_B0F  = 3'd2,
        MUL_B1H1 = 3'd3,
        MUL_B2H2 = 3'd4
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD      = 3'd0,
        ACC_LOAD_X    = 3'd1,
        ACC_LOAD_PROD = 3'd2,
        ACC_ADD_PROD  = 3'd3,
        ACC_SUB_PROD  = 3'd4,
        ACC_ADD_ROUND = 3'd5
    } acc_op_t;

    typedef struct packed {
        logic     load_item;
        logic     clear_hist;
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     f_load;
        logic     finish;
    } dp_cmd_t;

    typedef struct packed {
        logic item_clear;
        logic item_filter;
    } dp_status_t;

endpackage

### design/mbq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mbq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/mbq_regs.sv
// Configuration register block behind the APB-style port.
// Depends on mbq_pkg for register indexes and widths.
module mbq_regs #(
    parameter int COEF_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mbq_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    output logic signed [COEF_BITS-1:0]          coef_b0,
    output logic signed [COEF_BITS-1:0]          coef_b1,
    output logic signed [COEF_BITS-1:0]          coef_b2,
    output logic signed [COEF_BITS-1:0]          coef_a1,
    output logic signed [COEF_BITS-1:0]          coef_a2,
    output logic [mbq_pkg::ACTIVE_BITS-1:0]      active_channels
);

    import mbq_pkg::*;

    // Unity gain in the Q3 coefficient format.
    localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << (COEF_BITS - 4);

    logic [COEF_BITS-1:0]   b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic [ACTIVE_BITS-1:0] active_reg;
    logic [2:0]             index;
    logic                   wr_en;

    assign index  = paddr[CFG_ADDR_BITS-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg     <= COEF_ONE;
            b1_reg     <= '0;
            b2_reg     <= '0;
            a1_reg     <= '0;
            a2_reg     <= '0;
            active_reg <= ACTIVE_BITS'(2);
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_COEF_B0: b0_reg     <= pwdata[COEF_BITS-1:0];
                REG_COEF_B1: b1_reg     <= pwdata[COEF_BITS-1:0];
                REG_COEF_B2: b2_reg     <= pwdata[COEF_BITS-1:0];
                REG_COEF_A1: a1_reg     <= pwdata[COEF_BITS-1:0];
                REG_COEF_A2: a2_reg     <= pwdata[COEF_BITS-1:0];
                REG_ACTIVE:  active_reg <= pwdata[ACTIVE_BITS-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_COEF_B0: prdata = 32'($signed(b0_reg));
            REG_COEF_B1: prdata = 32'($signed(b1_reg));
            REG_COEF_B2: prdata = 32'($signed(b2_reg));
            REG_COEF_A1: prdata = 32'($signed(a1_reg));
            REG_COEF_A2: prdata = 32'($signed(a2_reg));
            REG_ACTIVE:  prdata = 32'(active_reg);
            default:     prdata = '0;
        endcase
    end

    assign coef_b0         = $signed(b0_reg);
    assign coef_b1         = $signed(b1_reg);
    assign coef_b2         = $signed(b2_reg);
    assign coef_a1         = $signed(a1_reg);
    assign coef_a2         = $signed(a2_reg);
    assign active_channels = active_reg;

endmodule

### design/mbq_ctrl.sv
// Controller state machine: sequences the shared multiplier and accumulator
// and owns the stream handshakes. Depends on mbq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  mbq_pkg::dp_status_t status,
    output mbq_pkg::dp_cmd_t    cmd
);

    import mbq_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_FB1  = 12'b0000_0000_0010,
        S_FB2  = 12'b0000_0000_0100,
        S_FB3  = 12'b0000_0000_1000,
        S_FBR  = 12'b0000_0001_0000,
        S_FBF  = 12'b0000_0010_0000,
        S_FF0  = 12'b0000_0100_0000,
        S_FF1  = 12'b0000_1000_0000,
        S_FF2  = 12'b0001_0000_0000,
        S_FF3  = 12'b0010_0000_0000,
        S_FFR  = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   filter_start;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign filter_start = s_tvalid && s_tready && status.item_filter && !status.item_clear;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    cmd.acc_op    = ACC_LOAD_X;
                    if (status.item_clear)
                    begin
                        cmd.clear_hist = 1'b1;
                    end
                    else if (status.item_filter)
                    begin
                        state_next = S_FB1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_FB1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_A1H1;
                state_next  = S_FB2;
            end
            S_FB2:
            begin
                cmd.acc_op  = ACC_SUB_PROD;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_A2H2;
                state_next  = S_FB3;
            end
            S_FB3:
            begin
                cmd.acc_op = ACC_SUB_PROD;
                state_next = S_FBR;
            end
            S_FBR:
            begin
                cmd.acc_op = ACC_ADD_ROUND;
                state_next = S_FBF;
            end
            S_FBF:
            begin
                cmd.f_load = 1'b1;
                state_next = S_FF0;
            end
            S_FF0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_B0F;
                state_next  = S_FF1;
            end
            S_FF1:
            begin
                cmd.acc_op  = ACC_LOAD_PROD;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_B1H1;
                state_next  = S_FF2;
            end
            S_FF2:
            begin
                cmd.acc_op  = ACC_ADD_PROD;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_B2H2;
                state_next  = S_FF3;
            end
            S_FF3:
            begin
                cmd.acc_op = ACC_ADD_PROD;
                state_next = S_FFR;
            end
            S_FFR:
            begin
                cmd.acc_op = ACC_ADD_ROUND;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // The result waits here until the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_NEVER(a_no_result_overwrite, clk, rst_n, cmd.finish && out_valid_reg && !m_tready)
    `ASSERT_PROP(a_filter_starts, clk, rst_n, filter_start |=> (state_reg == S_FB1))

endmodule

### design/mbq_dp.sv
// Datapath: history RAM with valid bits, shared multiplier, saturating
// accumulator and output register. Depends on mbq_pkg, mbq_ram, assert_macros.svh.
`include "assert_macros.svh"

module mbq_dp #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 24,
    parameter int COEF_BITS    = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mbq_pkg::dp_cmd_t                    cmd,
    output mbq_pkg::dp_status_t                 status,
    input  logic signed [COEF_BITS-1:0]         coef_b0,
    input  logic signed [COEF_BITS-1:0]         coef_b1,
    input  logic signed [COEF_BITS-1:0]         coef_b2,
    input  logic signed [COEF_BITS-1:0]         coef_a1,
    input  logic signed [COEF_BITS-1:0]         coef_a2,
    input  logic [mbq_pkg::ACTIVE_BITS-1:0]     active_channels,
    input  logic                                command,
    input  logic [mbq_pkg::CHAN_BITS-1:0]       channel,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    output logic [mbq_pkg::CHAN_BITS-1:0]       channel_out,
    output logic signed [SAMPLE_BITS-1:0]       sample_out
);

    import mbq_pkg::*;

    localparam int AW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int VDEPTH    = 1 << AW;
    localparam int COEF_FRAC = COEF_BITS - 4;
    localparam int PROD_W    = COEF_BITS + HIST_BITS;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [HIST_BITS-1:0]    HIST_MAX = {1'b0, {(HIST_BITS-1){1'b1}}};
    localparam logic [HIST_BITS-1:0]    HIST_MIN = {1'b1, {(HIST_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0]  SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0]  SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Item registers.
    logic [CHAN_BITS-1:0]          chan_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          filt_reg;

    // History storage.
    logic [VDEPTH-1:0]             valid_reg;
    logic                          rvalid_reg;
    logic [AW+CHAN_BITS-1:0]       rd_wide, wr_wide;
    logic [AW-1:0]                 rd_addr, wr_addr;
    logic [2*HIST_BITS-1:0]        rdata, wdata;
    logic signed [HIST_BITS-1:0]   h1, h2;
    logic                          hist_we;

    // Arithmetic.
    logic signed [COEF_BITS-1:0]   mul_a;
    logic signed [HIST_BITS-1:0]   mul_b;
    logic signed [PROD_W-1:0]      product;
    logic signed [ACC_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic signed [ACC_W-1:0]       addend;
    logic signed [ACC_W:0]         sum;
    logic signed [ACC_W-1:0]       sum_sat;
    logic signed [ACC_W-1:0]       shifted;
    logic [HIST_BITS-1:0]          f_sat;
    logic [SAMPLE_BITS-1:0]        y_sat;
    logic signed [HIST_BITS-1:0]   f_reg;
    logic [CHAN_BITS-1:0]          chan_out_reg;
    logic [SAMPLE_BITS-1:0]        smp_out_reg;

    assign status.item_clear  = (command == CMD_CLEAR);
    assign status.item_filter = (command == CMD_FILTER)
                              && ({1'b0, channel} < active_channels)
                              && (32'(channel) < MAX_CHANNELS);

    assign rd_wide = {{AW{1'b0}}, channel};
    assign wr_wide = {{AW{1'b0}}, chan_reg};
    assign rd_addr = rd_wide[AW-1:0];
    assign wr_addr = wr_wide[AW-1:0];
    assign hist_we = cmd.finish & filt_reg;

    // The new first history word is f; the old first word moves to second.
    assign wdata = {h1, f_reg};

    mbq_ram #(
        .WIDTH (2 * HIST_BITS),
        .DEPTH (MAX_CHANNELS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (wr_addr),
        .wdata (wdata),
        .re    (cmd.load_item),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // A row never written since reset or the last clear reads as zero.
    assign h1 = rvalid_reg ? $signed(rdata[HIST_BITS-1:0]) : '0;
    assign h2 = rvalid_reg ? $signed(rdata[2*HIST_BITS-1:HIST_BITS]) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
            filt_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clear_hist)
            begin
                valid_reg <= '0;
            end
            else if (hist_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.load_item)
            begin
                rvalid_reg <= valid_reg[rd_addr];
                filt_reg   <= status.item_filter;
            end
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_A1H1:
            begin
                mul_a = coef_a1;
                mul_b = h1;
            end
            MUL_A2H2:
            begin
                mul_a = coef_a2;
                mul_b = h2;
            end
            MUL_B0F:
            begin
                mul_a = coef_b0;
                mul_b = f_reg;
            end
            MUL_B1H1:
            begin
                mul_a = coef_b1;
                mul_b = h1;
            end
            MUL_B2H2:
            begin
                mul_a = coef_b2;
                mul_b = h2;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // Saturating add at the accumulator's signed limits.
    always_comb
    begin
        case (cmd.acc_op)
            ACC_SUB_PROD:  addend = -prod_reg;
            ACC_ADD_ROUND: addend = ROUND_HALF;
            default:       addend = prod_reg;
        endcase
        sum = {acc_reg[ACC_W-1], acc_reg} + {addend[ACC_W-1], addend};
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            sum_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            sum_sat = sum[ACC_W-1:0];
        end
    end

    always_comb
    begin
        case (cmd.acc_op)
            ACC_LOAD_X:    acc_next = ACC_W'(sample_in) <<< COEF_FRAC;
            ACC_LOAD_PROD: acc_next = prod_reg;
            ACC_ADD_PROD,
            ACC_SUB_PROD,
            ACC_ADD_ROUND: acc_next = sum_sat;
            default:       acc_next = acc_reg;
        endcase
    end

    // Floor shift out the coefficient fraction, then saturate to each width.
    assign shifted = acc_reg >>> COEF_FRAC;

    always_comb
    begin
        if ((&shifted[ACC_W-1:HIST_BITS-1]) || !(|shifted[ACC_W-1:HIST_BITS-1]))
        begin
            f_sat = shifted[HIST_BITS-1:0];
        end
        else
        begin
            f_sat = shifted[ACC_W-1] ? HIST_MIN : HIST_MAX;
        end
        if ((&shifted[ACC_W-1:SAMPLE_BITS-1]) || !(|shifted[ACC_W-1:SAMPLE_BITS-1]))
        begin
            y_sat = shifted[SAMPLE_BITS-1:0];
        end
        else
        begin
            y_sat = shifted[ACC_W-1] ? SMP_MIN : SMP_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            chan_reg <= channel;
            x_reg    <= sample_in;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= ACC_W'(product);
        end
        acc_reg <= acc_next;
        if (cmd.f_load)
        begin
            f_reg <= $signed(f_sat);
        end
        if (cmd.finish)
        begin
            chan_out_reg <= chan_reg;
            smp_out_reg  <= filt_reg ? y_sat : x_reg;
        end
    end

    assign channel_out = chan_out_reg;
    assign sample_out  = $signed(smp_out_reg);

    `ASSERT_PROP(a_clear_empties_history, clk, rst_n, cmd.clear_hist |=> (valid_reg == '0))
    `ASSERT_PROP(a_write_marks_row, clk, rst_n, hist_we |=> valid_reg[$past(wr_addr)])

endmodule

### design/multichannel_biquad_filter_unit.sv
// Multichannel biquad (direct form II) filter unit, top level.
// A filtered sample passes the feedback states and then the feed-forward states
// before it shows on m_tvalid; a pass-through sample skips both, and a clear
// gives no result. The unit takes one item at a time; a filtered sample needs
// five products sequenced through one shared multiplier and accumulator.
// Reset (async, active low) restores coefficients and empties all history.
module multichannel_biquad_filter_unit #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 24,
    parameter int COEF_BITS    = 24,
    localparam int TDATA_W = ((mbq_pkg::CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mbq_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [TDATA_W-1:0]                s_tdata,  // channel, sample_in
    input  logic                              s_tuser,  // command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [TDATA_W-1:0]                m_tdata   // channel_out, sample_out
);

    import mbq_pkg::*;

    logic signed [COEF_BITS-1:0]   coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
    logic [ACTIVE_BITS-1:0]        active_channels;
    dp_cmd_t                       cmd;
    dp_status_t                    status;
    logic [CHAN_BITS-1:0]          channel_out;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    mbq_regs #(
        .COEF_BITS (COEF_BITS)
    ) u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .coef_b0         (coef_b0),
        .coef_b1         (coef_b1),
        .coef_b2         (coef_b2),
        .coef_a1         (coef_a1),
        .coef_a2         (coef_a2),
        .active_channels (active_channels)
    );

    mbq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mbq_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COEF_BITS    (COEF_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .coef_b0         (coef_b0),
        .coef_b1         (coef_b1),
        .coef_b2         (coef_b2),
        .coef_a1         (coef_a1),
        .coef_a2         (coef_a2),
        .active_channels (active_channels),
        .command         (s_tuser),
        .channel         (s_tdata[CHAN_BITS-1:0]),
        .sample_in       ($signed(s_tdata[CHAN_BITS+SAMPLE_BITS-1:CHAN_BITS])),
        .channel_out     (channel_out),
        .sample_out      (sample_out)
    );

    assign m_tdata = TDATA_W'({sample_out, channel_out});

endmodule

### dv/testbench.sv
// Testbench for the multichannel biquad filter unit: streams samples and clears,
// predicts every output sample in a scoreboard class and checks them in order.
// Depends only on mbq_pkg and multichannel_biquad_filter_unit.
`timescale 1ns / 100ps

module testbench;
    import mbq_pkg::*;

    localparam int FRAC = 20;              // fraction bits of a Q3.20 coefficient
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        bit [2:0]  chan;
        bit [23:0] sample;
    } audio_result_t;

    class biquad_scoreboard;
        longint        coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
        bit [3:0]      active_count;
        longint        hist_one[8];
        longint        hist_two[8];
        audio_result_t expected_samples[$];
        int            mismatches;

        function new();
            coef_b0 = 1048576;
            coef_b1 = 0;
            coef_b2 = 0;
            coef_a1 = 0;
            coef_a2 = 0;
            active_count = 4'd2;
            mismatches = 0;
            foreach (hist_one[i])
            begin
                hist_one[i] = 0;
                hist_two[i] = 0;
            end
        endfunction

        function void write_register(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_COEF_B0: coef_b0 = longint'(signed'(value[23:0]));
                REG_COEF_B1: coef_b1 = longint'(signed'(value[23:0]));
                REG_COEF_B2: coef_b2 = longint'(signed'(value[23:0]));
                REG_COEF_A1: coef_a1 = longint'(signed'(value[23:0]));
                REG_COEF_A2: coef_a2 = longint'(signed'(value[23:0]));
                REG_ACTIVE:  active_count = value[3:0];
                default: ;
            endcase
        endfunction

        // Round half up, drop the coefficient fraction bits, saturate to w bits.
        function longint round_saturate(longint acc, int w);
            longint v, hi, lo;
            v = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
            hi = (64'sd1 <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        // At these widths every sum of products fits in 64 bits exactly.
        function void note_request(logic cmd, logic [2:0] ch, logic signed [23:0] x);
            longint        acc, f, y, h1, h2;
            audio_result_t res;
            if (cmd == CMD_CLEAR)
            begin
                foreach (hist_one[i])
                begin
                    hist_one[i] = 0;
                    hist_two[i] = 0;
                end
                return;
            end
            res.chan = ch;
            // The channel field cannot reach eight, so the channel count alone decides.
            if (ch < active_count)
            begin
                h1 = hist_one[ch];
                h2 = hist_two[ch];
                acc = longint'(x) <<< FRAC;
                acc = acc - coef_a1 * h1 - coef_a2 * h2;
                f = round_saturate(acc, HIST_BITS);
                acc = coef_b0 * f + coef_b1 * h1 + coef_b2 * h2;
                y = round_saturate(acc, 24);
                hist_two[ch] = h1;
                hist_one[ch] = f;
                res.sample = y[23:0];
            end
            else
                res.sample = x;
            expected_samples.push_back(res);
        endfunction

        task report_mismatch(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_result(logic [2:0] ch, logic [23:0] y);
            audio_result_t exp_res;
            if (expected_samples.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result ch %0d sample %h", ch, y));
                return;
            end
            exp_res = expected_samples.pop_front();
            if (ch !== exp_res.chan)
                report_mismatch($sformatf("channel %0d, expected %0d", ch, exp_res.chan));
            if (y !== exp_res.sample)
                report_mismatch($sformatf("ch %0d sample %h, expected %h",
                                          exp_res.chan, y, exp_res.sample));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // channel [2:0], sample_in [26:3]
    logic        s_tuser = 1'b0; // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // channel_out [2:0], sample_out [26:3]

    int idle_pct = 0;
    int stall_pct = 0;

    biquad_scoreboard sb = new();

    multichannel_biquad_filter_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: check what was accepted at this edge, then pick the next ready.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[2:0], m_tdata[26:3]);
        m_tready <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    task write_reg(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_register(idx, value);
        @(posedge clk);
    endtask

    task send_request(logic cmd, logic [2:0] ch, logic [23:0] x);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {5'b0, x, ch};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(cmd, ch, x);
    endtask

    // A clear leaves nothing to wait for, so a few spare cycles cover its tail.
    task wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_samples.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    function logic [31:0] pick_coef();
        logic [23:0] v;
        case ($urandom_range(9))
            0: v = 24'h7FFFFF;
            1: v = 24'h800000;
            2, 3, 4, 5: v = 24'($urandom);
            default: v = 24'($urandom_range(2 * 1048576) - 1048576);
        endcase
        return {8'h0, v};
    endfunction

    function logic [23:0] pick_sample();
        case ($urandom_range(19))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3, 4, 5, 6: return 24'($urandom_range(2000) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    task configure_phase(int phase);
        logic [31:0] active_val;
        case ($urandom_range(5))
            0: active_val = 32'd0;
            1: active_val = 32'd8;
            2: active_val = 32'd15;
            default: active_val = $urandom_range(8, 1);
        endcase
        if (phase % 3 == 0)
        begin
            // A stable low-pass section keeps most outputs out of saturation.
            write_reg(REG_COEF_B0, 32'd70000 + $urandom_range(255));
            write_reg(REG_COEF_B1, 32'd140000);
            write_reg(REG_COEF_B2, 32'd70000);
            write_reg(REG_COEF_A1, {8'h0, 24'(-1500000)});
            write_reg(REG_COEF_A2, 32'd600000);
        end
        else
        begin
            write_reg(REG_COEF_B0, pick_coef());
            write_reg(REG_COEF_B1, pick_coef());
            write_reg(REG_COEF_B2, pick_coef());
            write_reg(REG_COEF_A1, pick_coef());
            write_reg(REG_COEF_A2, pick_coef());
        end
        write_reg(REG_ACTIVE, active_val);
        case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 68; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 68; end
            default: begin idle_pct = 21; stall_pct = 21; end
        endcase
    endtask

    initial
    begin
        int   phase;
        int   n;
        logic cmd;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: unity gain on channels 0 and 1, the rest pass through.
        send_request(CMD_FILTER, 3'd0, 24'h7FFFFF);
        send_request(CMD_FILTER, 3'd0, 24'h800000);
        send_request(CMD_FILTER, 3'd1, 24'h000000);
        send_request(CMD_FILTER, 3'd1, 24'hFFFFFF);
        send_request(CMD_FILTER, 3'd2, 24'h123456);
        send_request(CMD_FILTER, 3'd7, 24'h800000);
        send_request(CMD_CLEAR, 3'd5, 24'hABCDEF);
        wait_drained();

        // Extreme coefficients drive both history and output into saturation;
        // a channel count above eight filters every channel.
        write_reg(REG_COEF_B0, 32'h007FFFFF);
        write_reg(REG_COEF_B1, 32'h00800000);
        write_reg(REG_COEF_B2, 32'h007FFFFF);
        write_reg(REG_COEF_A1, 32'h00800000);
        write_reg(REG_COEF_A2, 32'h007FFFFF);
        write_reg(REG_ACTIVE, 32'd15);
        write_reg(REG_SPARE_LO, 32'hFFFFFFFF);
        write_reg(REG_SPARE_HI, 32'hFFFFFFFF);
        for (n = 0; n < 8; n++)
            send_request(CMD_FILTER, 3'(n), (n % 2) ? 24'h800000 : 24'h7FFFFF);
        send_request(CMD_FILTER, 3'd3, 24'h7FFFFF);
        send_request(CMD_FILTER, 3'd3, 24'h800000);
        send_request(CMD_CLEAR, 3'd0, 24'h000000);
        send_request(CMD_FILTER, 3'd0, 24'h000000);
        wait_drained();

        // No channel filtered, then all eight.
        write_reg(REG_ACTIVE, 32'd0);
        send_request(CMD_FILTER, 3'd0, 24'h7FFFFF);
        send_request(CMD_FILTER, 3'd5, 24'h800000);
        wait_drained();
        write_reg(REG_ACTIVE, 32'd8);
        send_request(CMD_FILTER, 3'd7, 24'h7FFFFF);
        wait_drained();

        for (phase = 0; phase < 10; phase++)
        begin
            configure_phase(phase);
            for (n = 0; n < 65; n++)
            begin
                cmd = ($urandom_range(99) < 4) ? CMD_CLEAR : CMD_FILTER;
                send_request(cmd, 3'($urandom_range(7)), pick_sample());
            end
            wait_drained();
        end

        if (sb.mismatches == 0 && sb.expected_samples.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
